[rtl/lzhd_pkg.sv]
// lzhd_pkg: shared types and constants of the lz history decompressor
// used by lzhd_parser, lzhd_hist, lzhd_engine and the top level

package lzhd_pkg;

  localparam int SIZE_W = 32;
  localparam int DIST_W = 13;
  localparam int LEN_W  = 9;
  localparam int OUT_W  = 64;
  localparam int CNT_W  = 4;

  localparam logic [4:0]       HDR_LEN   = 5'd16;
  localparam logic [4:0]       MAGIC_END = 5'd4;
  localparam logic [4:0]       SIZE_END  = 5'd8;
  localparam logic [7:0]       MAGIC [4] = '{8'h59, 8'h61, 8'h7a, 8'h30};
  localparam logic [LEN_W-1:0] LONG_BIAS = 9'h012;
  localparam logic [LEN_W-1:0] SHORT_BIAS = 9'h002;
  localparam logic [LEN_W-1:0] MIN_RUN   = 9'h003;
  localparam logic [LEN_W-1:0] MAX_RUN   = 9'h111;
  localparam logic [3:0]       GROUP_FLAGS = 4'd8;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_REF,
    CMD_MARK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              clear;
    logic [7:0]        lit;
    logic [DIST_W-1:0] ref_dist;
    logic [LEN_W-1:0]  len;
    logic              status;
    logic              done;
  } lzhd_cmd_t;

  typedef struct packed {
    logic clr;
    logic wr_en;
    logic rd_en;
  } hist_ctl_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_COPY
  } eng_state_t;

endpackage

[rtl/lzhd_parser.sv]
// lzhd_parser: header, group flag and back-reference byte parser
// turns each accepted stream byte into a command; depends on lzhd_pkg

module lzhd_parser import lzhd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       first_byte,
  output lzhd_cmd_t  cmd
);

  logic [4:0]        hp_r, hp, hp_nxt;
  logic [SIZE_W-1:0] size_r, size, size_nxt;
  logic [7:0]        gflags_r, gflags, gflags_nxt;
  logic [3:0]        fleft_r, fleft, fleft_nxt;
  logic [7:0]        rb0_r, rb0, rb0_nxt;
  logic [7:0]        rb1_r, rb1, rb1_nxt, rb1_use;
  logic [1:0]        rcnt_r, rcnt, rcnt_nxt;
  logic [SIZE_W-1:0] tot_r, tot, tot_nxt;
  logic              fin_r, fin, fin_nxt;
  logic              mbad_r, mbad, mbad_nxt;
  logic              run;
  logic [LEN_W-1:0]  run_len;
  logic [SIZE_W:0]   tot_sum;
  logic [2:0]        flag_idx;

  always_comb begin
    hp     = first_byte ? '0 : hp_r;
    size   = first_byte ? '0 : size_r;
    gflags = first_byte ? '0 : gflags_r;
    fleft  = first_byte ? '0 : fleft_r;
    rb0    = first_byte ? '0 : rb0_r;
    rb1    = first_byte ? '0 : rb1_r;
    rcnt   = first_byte ? '0 : rcnt_r;
    tot    = first_byte ? '0 : tot_r;
    fin    = first_byte ? 1'b0 : fin_r;
    mbad   = first_byte ? 1'b0 : mbad_r;

    hp_nxt     = hp;
    size_nxt   = size;
    gflags_nxt = gflags;
    fleft_nxt  = fleft;
    rb0_nxt    = rb0;
    rb1_nxt    = rb1;
    rcnt_nxt   = rcnt;
    tot_nxt    = tot;
    fin_nxt    = fin;
    mbad_nxt   = mbad;

    run      = 1'b0;
    run_len  = '0;
    tot_sum  = '0;
    flag_idx = 3'(fleft - 4'd1);
    rb1_use  = (rcnt == 2'd1) ? in_byte : rb1;

    cmd          = '0;
    cmd.kind     = CMD_NONE;
    cmd.clear    = first_byte;
    cmd.lit      = in_byte;
    cmd.ref_dist = {1'b0, rb0[3:0], rb1_use} + DIST_W'(1);

    if (hp < HDR_LEN) begin
      if (hp < MAGIC_END && in_byte != MAGIC[hp[1:0]]) begin
        mbad_nxt = 1'b1;
      end else if (hp >= MAGIC_END && hp < SIZE_END) begin
        size_nxt = {size[SIZE_W-9:0], in_byte};
      end
      hp_nxt = hp + 5'd1;
      if (hp_nxt == HDR_LEN) begin
        if (mbad_nxt) begin
          cmd.kind   = CMD_MARK;
          cmd.status = 1'b1;
        end else if (size_nxt == '0) begin
          fin_nxt  = 1'b1;
          cmd.kind = CMD_MARK;
          cmd.done = 1'b1;
        end
      end
    end else if (mbad || fin) begin
      // ignored until the next stream
    end else if (fleft == '0) begin
      gflags_nxt = in_byte;
      fleft_nxt  = GROUP_FLAGS;
    end else begin
      priority if (gflags[flag_idx]) begin
        run      = 1'b1;
        run_len  = LEN_W'(1);
        cmd.kind = CMD_LIT;
      end else if (rcnt == 2'd0) begin
        rb0_nxt  = in_byte;
        rcnt_nxt = 2'd1;
      end else if (rcnt == 2'd1) begin
        rb1_nxt  = in_byte;
        rcnt_nxt = 2'd2;
        if (rb0[7:4] != 4'd0) begin
          run      = 1'b1;
          run_len  = LEN_W'(rb0[7:4]) + SHORT_BIAS;
          cmd.kind = CMD_REF;
        end
      end else begin
        run      = 1'b1;
        run_len  = LEN_W'(in_byte) + LONG_BIAS;
        cmd.kind = CMD_REF;
      end
      if (run) begin
        rcnt_nxt  = 2'd0;
        fleft_nxt = fleft - 4'd1;
        tot_sum   = {1'b0, tot} + (SIZE_W+1)'(run_len);
        tot_nxt   = tot_sum[SIZE_W] ? '1 : tot_sum[SIZE_W-1:0];
        if (tot_nxt >= size) begin
          fin_nxt  = 1'b1;
          cmd.done = 1'b1;
        end
      end
    end
    cmd.len = run_len;

    if (!accept) begin
      cmd.kind  = CMD_NONE;
      cmd.clear = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r     <= '0;
      size_r   <= '0;
      gflags_r <= '0;
      fleft_r  <= '0;
      rb0_r    <= '0;
      rb1_r    <= '0;
      rcnt_r   <= '0;
      tot_r    <= '0;
      fin_r    <= 1'b0;
      mbad_r   <= 1'b0;
    end else if (accept) begin
      hp_r     <= hp_nxt;
      size_r   <= size_nxt;
      gflags_r <= gflags_nxt;
      fleft_r  <= fleft_nxt;
      rb0_r    <= rb0_nxt;
      rb1_r    <= rb1_nxt;
      rcnt_r   <= rcnt_nxt;
      tot_r    <= tot_nxt;
      fin_r    <= fin_nxt;
      mbad_r   <= mbad_nxt;
    end
  end

endmodule

[rtl/lzhd_hist.sv]
// lzhd_hist: history ring memory, one write and one read port, registered read
// fill counter reads unwritten entries as zero; depends on lzhd_pkg

module lzhd_hist import lzhd_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hist_ctl_t     ctl,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  localparam logic [AW:0] DEPTH_X = (AW+1)'(DEPTH);

  logic [7:0]  mem [DEPTH];
  logic [7:0]  mem_q_r;
  logic [7:0]  byp_data_r;
  logic        byp_r;
  logic        valid_r;
  logic [AW:0] fill_r, fill_nxt;
  logic        hit, written;

  assign hit     = ctl.wr_en && (wr_addr == rd_addr);
  assign written = (fill_r == DEPTH_X) || ({1'b0, rd_addr} < fill_r) || hit;

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.clr) begin
      fill_nxt = '0;
    end else if (ctl.wr_en && fill_r != DEPTH_X) begin
      fill_nxt = fill_r + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_q_r    <= mem[rd_addr];
      byp_r      <= hit;
      byp_data_r <= wr_data;
      valid_r    <= written;
    end
  end

  assign rd_data = !valid_r ? 8'h00 : (byp_r ? byp_data_r : mem_q_r);

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_X)
    else $error("history fill count beyond depth");

endmodule

[rtl/lzhd_engine.sv]
// lzhd_engine: literal store, back-reference copy, byte packing and result register
// drives the history memory lzhd_hist; depends on lzhd_pkg

module lzhd_engine import lzhd_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int BPR   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lzhd_cmd_t   cmd,
  output logic        idle,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  output logic        out_tlast,
  output logic [1:0]  out_tuser
);

  localparam int AW  = $clog2(DEPTH);
  localparam int PKW = $clog2(BPR + 1);
  localparam logic [AW:0]    DEPTH_X = (AW+1)'(DEPTH);
  localparam logic [AW-1:0]  LAST_A  = AW'(DEPTH - 1);
  localparam logic [PKW-1:0] BPR_C   = PKW'(BPR);

  eng_state_t        state_r, state_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic              pend_r, pend_nxt;
  logic [7:0]        pk_r [BPR];
  logic [7:0]        pk_nxt [BPR];
  logic [PKW-1:0]    pk_cnt_r, pk_cnt_nxt;
  logic              run_done_r, run_done_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_bytes_r, out_bytes_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_done_r, out_done_nxt;

  hist_ctl_t         hctl;
  logic [AW-1:0]     wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        rd_data;

  logic              slot_free, issue, flush_want, flush_go, run_end;
  logic [PKW:0]      cnt_sum;
  logic [AW:0]       diff;
  logic [AW-1:0]     start;
  logic [OUT_W-1:0]  pk_flat;

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
    next_addr = (a == LAST_A) ? '0 : a + AW'(1);
  endfunction

  lzhd_hist #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (hctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  assign slot_free  = !out_valid_r || out_tready;
  assign idle       = (state_r == ENG_IDLE) && slot_free;
  assign cnt_sum    = {1'b0, pk_cnt_r} + (PKW+1)'(pend_r);
  assign issue      = (state_r == ENG_COPY) && (remain_r != '0) && (cnt_sum < {1'b0, BPR_C});
  assign flush_want = (state_r == ENG_COPY) &&
                      ((pk_cnt_r == BPR_C) ||
                       (remain_r == '0 && !pend_r && pk_cnt_r != '0));
  assign flush_go   = flush_want && slot_free;
  assign run_end    = flush_go && (remain_r == '0);

  assign diff  = {1'b0, wp_r} - (AW+1)'(cmd.ref_dist);
  assign start = diff[AW] ? AW'(diff + DEPTH_X) : diff[AW-1:0];

  always_comb begin
    pk_flat = '0;
    for (int i = 0; i < BPR; i++) begin
      pk_flat[8*i +: 8] = pk_r[i];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENG_IDLE: begin
        if (cmd.kind == CMD_REF) begin
          state_nxt = ENG_COPY;
        end
      end
      ENG_COPY: begin
        if (run_end) begin
          state_nxt = ENG_IDLE;
        end
      end
      default: state_nxt = ENG_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    hctl           = '0;
    wr_addr        = wp_r;
    wr_data        = rd_data;
    wp_nxt         = wp_r;
    rd_addr_nxt    = rd_addr_r;
    remain_nxt     = remain_r;
    pend_nxt       = 1'b0;
    pk_nxt         = pk_r;
    pk_cnt_nxt     = pk_cnt_r;
    run_done_nxt   = run_done_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_bytes_nxt  = out_bytes_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_done_nxt   = out_done_r;

    unique case (state_r)
      ENG_IDLE: begin
        if (cmd.clear) begin
          hctl.clr = 1'b1;
          wp_nxt   = '0;
        end
        unique case (cmd.kind)
          CMD_LIT: begin
            hctl.wr_en     = 1'b1;
            wr_data        = cmd.lit;
            wp_nxt         = next_addr(wp_r);
            out_valid_nxt  = 1'b1;
            out_bytes_nxt  = OUT_W'(cmd.lit);
            out_cnt_nxt    = CNT_W'(1);
            out_last_nxt   = 1'b1;
            out_status_nxt = 1'b0;
            out_done_nxt   = cmd.done;
          end
          CMD_MARK: begin
            out_valid_nxt  = 1'b1;
            out_bytes_nxt  = '0;
            out_cnt_nxt    = '0;
            out_last_nxt   = 1'b1;
            out_status_nxt = cmd.status;
            out_done_nxt   = cmd.done;
          end
          CMD_REF: begin
            rd_addr_nxt  = start;
            remain_nxt   = cmd.len;
            run_done_nxt = cmd.done;
            pk_cnt_nxt   = '0;
            for (int i = 0; i < BPR; i++) begin
              pk_nxt[i] = 8'h00;
            end
          end
          CMD_NONE: begin
          end
          default: begin
          end
        endcase
      end
      ENG_COPY: begin
        if (issue) begin
          hctl.rd_en  = 1'b1;
          rd_addr_nxt = next_addr(rd_addr_r);
          remain_nxt  = remain_r - LEN_W'(1);
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          hctl.wr_en = 1'b1;
          wp_nxt     = next_addr(wp_r);
          for (int i = 0; i < BPR; i++) begin
            if (PKW'(i) == pk_cnt_r) begin
              pk_nxt[i] = rd_data;
            end
          end
          pk_cnt_nxt = pk_cnt_r + PKW'(1);
        end
        if (flush_go) begin
          out_valid_nxt  = 1'b1;
          out_bytes_nxt  = pk_flat;
          out_cnt_nxt    = CNT_W'(pk_cnt_r);
          out_last_nxt   = run_end;
          out_status_nxt = 1'b0;
          out_done_nxt   = run_end && run_done_r;
          pk_cnt_nxt     = '0;
          for (int i = 0; i < BPR; i++) begin
            pk_nxt[i] = 8'h00;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      wp_r        <= '0;
      remain_r    <= '0;
      pend_r      <= 1'b0;
      pk_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      remain_r    <= remain_nxt;
      pend_r      <= pend_nxt;
      pk_cnt_r    <= pk_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    pk_r         <= pk_nxt;
    run_done_r   <= run_done_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_cnt_r, out_bytes_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_done_r, out_status_r};

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ENG_IDLE |-> !pend_r && pk_cnt_r == '0)
    else $error("copy left data behind on return to idle");

  a_no_flush_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !flush_go)
    else $error("pack buffer flushed while history data arrives");

  a_ref_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.kind == CMD_REF |-> cmd.len >= MIN_RUN && cmd.len <= MAX_RUN)
    else $error("back-reference length out of range");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cnt_r == '0 |-> out_last_r)
    else $error("empty beat not marked last");

endmodule

[rtl/lz_history_decompressor_top.sv]
// lz_history_decompressor_top: lz stream decompressor with a history ring
// instantiates lzhd_parser and lzhd_engine; depends on lzhd_pkg
//
//  channel | dir | ports                            | beat
//  in      | in  | in_tvalid in_tready in_tdata ... | one compressed byte
//  out     | out | out_tvalid out_tready out_tdata  | up to eight output bytes
//
// a literal leaves one beat in the output register
// a back-reference copy is paced by the single history read port (one byte a cycle
// while the pack buffer has room) and by the pack buffer flush
// no clearing pass after reset: a fill counter reads unwritten history as zero
// an output stall holds the copy at the pack buffer; input waits while copying

module lz_history_decompressor_top import lzhd_pkg::*; #(
  parameter int HISTORY_DEPTH    = 4096,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic [0:0]  in_tuser,   // [0] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] out_bytes, [67:64] byte_count, rest zero
  output logic        out_tlast,  // run_last
  output logic [1:0]  out_tuser   // [0] status, [1] stream_done
);

  lzhd_cmd_t cmd;
  logic      accept;
  logic      idle;

  assign in_tready = idle;
  assign accept    = in_tvalid && in_tready;

  lzhd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .in_byte    (in_tdata),
    .first_byte (in_tuser[0]),
    .cmd        (cmd)
  );

  lzhd_engine #(
    .DEPTH (HISTORY_DEPTH),
    .BPR   (BYTES_PER_RESULT)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .idle       (idle),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
